// ----- src/neighbor_repulsion_force_defines.svh -----
// assertion macros used by the checker file
`ifndef NEIGHBOR_REPULSION_FORCE_DEFINES_SVH
`define NEIGHBOR_REPULSION_FORCE_DEFINES_SVH

// consequent must hold in the cycle after the antecedent
`define NRF_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define NRF_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- src/nrf_pkg.sv -----
// ----------------------------------------------------------------------------
// nrf_pkg
// Shared constants, codes and controller/datapath types for the block.
// ----------------------------------------------------------------------------
package nrf_pkg;

    localparam int NEIGHBORS = 8;
    localparam int IDX_W     = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
    localparam int CNT_W     = $clog2(NEIGHBORS + 1);

    localparam int DATA_W = 104;
    localparam int USER_W = 1;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    localparam int ACC_W      = 52;
    localparam int DIV_W      = 70;
    localparam int DIVS_W     = 64;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

    localparam logic [31:0] NEAR_LIMIT = 32'd655;
    localparam logic [11:0] ZBIAS      = 12'd3277;
    localparam logic [45:0] MAG_CAP    = '1;

    typedef enum logic [CFG_AW-1:0] {
        REG_SAFE_DIST = 3'd0,
        REG_GAIN      = 3'd1,
        REG_SCALE     = 3'd2,
        REG_OFS_X     = 3'd3,
        REG_OFS_Y     = 3'd4,
        REG_OFS_Z     = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        ITEM_STORE   = 1'b0,
        ITEM_COMPUTE = 1'b1
    } item_op_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_NEXT, ST_LOAD, ST_GUARD, ST_SQ, ST_SQRT_GO, ST_SQRT_WAIT,
        ST_BAND, ST_DIVD_WAIT, ST_DIVR, ST_DIVR_WAIT, ST_TMUL, ST_MAG_GO,
        ST_MAG_WAIT, ST_MAG_SAVE, ST_DIR_GO, ST_DIR_WAIT, ST_DMUL, ST_DACC,
        ST_BIAS, ST_BACC, ST_SLO, ST_SHI, ST_SSUM, ST_OUT
    } state_t;

    typedef enum logic [4:0] {
        DP_NOP, DP_STORE, DP_START, DP_LOAD, DP_SQ, DP_SQRT_GO, DP_BAND_GO,
        DP_DIVR_GO, DP_TMUL, DP_MAG_GO, DP_MAG_SAVE, DP_DIR_GO, DP_DMUL,
        DP_DACC, DP_BIAS, DP_BACC, DP_SLO, DP_SHI, DP_SSUM, DP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        logic [IDX_W-1:0] idx;
        axis_t            axis;
    } dp_cmd_t;

    typedef struct packed {
        logic nbr_valid;
        logic outside;
        logic in_band;
        logic div_busy;
        logic sqrt_busy;
        logic out_free;
    } dp_status_t;

endpackage

// ----- src/nrf_div.sv -----
// ----------------------------------------------------------------------------
// nrf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nrf_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [nrf_pkg::DIV_W-1:0]   dividend,
    input  logic [nrf_pkg::DIVS_W-1:0]  divisor,
    output logic                        busy,
    output logic [nrf_pkg::DIV_W-1:0]   quot
);

    logic [nrf_pkg::DIV_W-1:0]     q_reg;
    logic [nrf_pkg::DIVS_W-1:0]    r_reg;
    logic [nrf_pkg::DIVS_W-1:0]    den_reg;
    logic [nrf_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;

    logic [nrf_pkg::DIVS_W:0] r_sh;
    logic [nrf_pkg::DIVS_W:0] diff;
    logic                     ge;

    assign r_sh = {r_reg, q_reg[nrf_pkg::DIV_W-1]};
    assign diff = r_sh - {1'b0, den_reg};
    assign ge   = (r_sh >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= nrf_pkg::DIV_CNT_W'(nrf_pkg::DIV_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == nrf_pkg::DIV_CNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            r_reg   <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[nrf_pkg::DIV_W-2:0], ge};
            r_reg <= ge ? diff[nrf_pkg::DIVS_W-1:0] : r_sh[nrf_pkg::DIVS_W-1:0];
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

// ----- src/nrf_sqrt.sv -----
// ----------------------------------------------------------------------------
// nrf_sqrt
// Integer square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module nrf_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        busy,
    output logic [31:0] root
);

    logic [63:0] x_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic        busy_reg;

    logic [64:0] trial;
    logic        ge;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};
    assign ge    = ({1'b0, x_reg} >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (start)
            busy_reg <= 1'b1;
        else if (busy_reg && bit_reg[0])
            busy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                x_reg   <= x_reg - trial[63:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign busy = busy_reg;
    assign root = res_reg[31:0];

endmodule

// ----- src/nrf_datapath.sv -----
// ----------------------------------------------------------------------------
// nrf_datapath
// Neighbor table, configuration registers, arithmetic and output register.
// ----------------------------------------------------------------------------
module nrf_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [nrf_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [nrf_pkg::CFG_DW-1:0]  cfg_wdata,
    input  logic [2:0]                  in_slot,
    input  logic signed [31:0]          in_pos_x,
    input  logic signed [31:0]          in_pos_y,
    input  logic signed [31:0]          in_pos_z,
    input  nrf_pkg::dp_cmd_t            cmd,
    output nrf_pkg::dp_status_t         status,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [31:0]                 out_force_x,
    output logic [31:0]                 out_force_y,
    output logic [31:0]                 out_force_z,
    output logic                        out_active
);

    // configuration
    logic [30:0]        safe_dist_reg;
    logic [30:0]        gain_reg;
    logic signed [31:0] scale_reg;
    logic signed [31:0] ofs_reg [3];

    // neighbor table
    logic signed [31:0]          nbr_x_reg [nrf_pkg::NEIGHBORS];
    logic signed [31:0]          nbr_y_reg [nrf_pkg::NEIGHBORS];
    logic signed [31:0]          nbr_z_reg [nrf_pkg::NEIGHBORS];
    logic [nrf_pkg::NEIGHBORS-1:0] valid_reg;

    // working registers
    logic signed [32:0]               own_reg [3];
    logic [33:0]                      a_reg [3];
    logic                             neg_reg [3];
    logic [63:0]                      d2_reg;
    logic [23:0]                      q1_reg;
    logic [37:0]                      t_reg;
    logic [45:0]                      mag_reg;
    logic [62:0]                      prod_reg;
    logic [53:0]                      prod2_reg;
    logic                             sat_reg;
    logic signed [nrf_pkg::ACC_W-1:0] acc_reg [3];
    logic                             active_reg;
    logic [31:0]                      res_reg [3];

    logic        out_valid_reg;
    logic [31:0] out_fx_reg;
    logic [31:0] out_fy_reg;
    logic [31:0] out_fz_reg;
    logic        out_active_reg;

    // arithmetic units
    logic                          div_start;
    logic [nrf_pkg::DIV_W-1:0]     div_dividend;
    logic [nrf_pkg::DIVS_W-1:0]    div_divisor;
    logic                          div_busy;
    logic [nrf_pkg::DIV_W-1:0]     quot;
    logic                          sqrt_busy;
    logic [31:0]                   d;

    logic signed [31:0] pos [3];
    logic signed [31:0] nbr_rd [3];
    logic signed [33:0] dv [3];
    logic [33:0]        abs_dv [3];
    logic [2:0]         outside_c;

    logic [61:0]                      sq;
    logic [23:0]                      u;
    logic [54:0]                      tprod;
    logic [62:0]                      dprod;
    logic [57:0]                      bprod;
    logic signed [nrf_pkg::ACC_W-1:0] term;
    logic signed [nrf_pkg::ACC_W-1:0] acc_sel;
    logic [nrf_pkg::ACC_W-1:0]        m_abs;
    logic [30:0]                      sc;
    logic [54:0]                      lo_prod;
    logic [53:0]                      hi_prod;
    logic [78:0]                      full;
    logic [62:0]                      p;
    logic [31:0]                      sat_out;
    logic                             scale_off;

    assign pos[0] = in_pos_x;
    assign pos[1] = in_pos_y;
    assign pos[2] = in_pos_z;

    assign nbr_rd[0] = nbr_x_reg[cmd.idx];
    assign nbr_rd[1] = nbr_y_reg[cmd.idx];
    assign nbr_rd[2] = nbr_z_reg[cmd.idx];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            dv[c]        = 34'(own_reg[c]) - 34'(nbr_rd[c]);
            abs_dv[c]    = dv[c][33] ? 34'(-dv[c]) : 34'(dv[c]);
            outside_c[c] = (a_reg[c] >= 34'(safe_dist_reg));
        end
    end

    assign sq      = a_reg[cmd.axis][30:0] * a_reg[cmd.axis][30:0];
    assign u       = q1_reg - quot[23:0];
    assign tprod   = gain_reg * u;
    assign dprod   = mag_reg * quot[16:0];
    assign bprod   = mag_reg * nrf_pkg::ZBIAS;
    assign term    = signed'({{(nrf_pkg::ACC_W-47){1'b0}}, prod_reg[62:16]});
    assign acc_sel = acc_reg[cmd.axis];
    assign m_abs   = acc_sel[nrf_pkg::ACC_W-1] ? nrf_pkg::ACC_W'(-acc_sel)
                                               : nrf_pkg::ACC_W'(acc_sel);
    assign sc        = scale_reg[30:0];
    assign lo_prod   = m_abs[23:0] * sc;
    assign hi_prod   = m_abs[46:24] * sc;
    assign full      = 79'(prod_reg) + 79'({prod2_reg, 24'b0});
    assign p         = full[78:16];
    assign scale_off = scale_reg[31] || (scale_reg == 32'sd0);

    // sign-magnitude scale result saturated to the signed 32-bit range, zero when the scale is not positive
    always_comb
    begin
        if (scale_off)
            sat_out = '0;
        else if (acc_sel[nrf_pkg::ACC_W-1])
            sat_out = (sat_reg || (p > 63'h8000_0000)) ? 32'h8000_0000 : -p[31:0];
        else
            sat_out = (sat_reg || (p > 63'h7FFF_FFFF)) ? 32'h7FFF_FFFF : p[31:0];
    end

    // divider operand select
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = nrf_pkg::DIV_W'(64'h1_0000_0000);
        div_divisor  = 64'(d);
        case (cmd.op)
            nrf_pkg::DP_BAND_GO:
            begin
                div_start = 1'b1;
            end
            nrf_pkg::DP_DIVR_GO:
            begin
                div_start   = 1'b1;
                div_divisor = 64'(safe_dist_reg);
            end
            nrf_pkg::DP_MAG_GO:
            begin
                div_start    = 1'b1;
                div_dividend = {t_reg, 32'b0};
                div_divisor  = d2_reg;
            end
            nrf_pkg::DP_DIR_GO:
            begin
                div_start    = 1'b1;
                div_dividend = nrf_pkg::DIV_W'({a_reg[cmd.axis][30:0], 16'b0});
            end
            default:
            begin
            end
        endcase
    end

    nrf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quot     (quot)
    );

    nrf_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == nrf_pkg::DP_SQRT_GO),
        .radicand (d2_reg),
        .busy     (sqrt_busy),
        .root     (d)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            safe_dist_reg <= 31'd65536;
            gain_reg      <= 31'd65536;
            scale_reg     <= '0;
            ofs_reg[0]    <= '0;
            ofs_reg[1]    <= '0;
            ofs_reg[2]    <= '0;
        end
        else if (cfg_we)
        begin
            case (nrf_pkg::cfg_reg_t'(cfg_addr))
                nrf_pkg::REG_SAFE_DIST: safe_dist_reg <= cfg_wdata[30:0];
                nrf_pkg::REG_GAIN:      gain_reg      <= cfg_wdata[30:0];
                nrf_pkg::REG_SCALE:     scale_reg     <= signed'(cfg_wdata);
                nrf_pkg::REG_OFS_X:     ofs_reg[0]    <= signed'(cfg_wdata);
                nrf_pkg::REG_OFS_Y:     ofs_reg[1]    <= signed'(cfg_wdata);
                nrf_pkg::REG_OFS_Z:     ofs_reg[2]    <= signed'(cfg_wdata);
                default:
                begin
                end
            endcase
        end
    end

    // slots at or beyond the table depth never match and are dropped
    always_ff @(posedge clk)
    begin
        if (cmd.op == nrf_pkg::DP_STORE)
        begin
            for (int i = 0; i < nrf_pkg::NEIGHBORS; i++)
            begin
                if (32'(in_slot) == i)
                begin
                    nbr_x_reg[i] <= in_pos_x;
                    nbr_y_reg[i] <= in_pos_y;
                    nbr_z_reg[i] <= in_pos_z;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == nrf_pkg::DP_STORE)
            begin
                for (int i = 0; i < nrf_pkg::NEIGHBORS; i++)
                begin
                    if (32'(in_slot) == i)
                        valid_reg[i] <= 1'b1;
                end
            end
            if (cmd.op == nrf_pkg::DP_START)
                active_reg <= 1'b0;
            else if (cmd.op == nrf_pkg::DP_BAND_GO)
                active_reg <= 1'b1;
            if (cmd.op == nrf_pkg::DP_OUT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            nrf_pkg::DP_START:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    own_reg[c] <= 33'(pos[c]) + 33'(ofs_reg[c]);
                    acc_reg[c] <= '0;
                end
            end
            nrf_pkg::DP_LOAD:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    a_reg[c]   <= abs_dv[c];
                    neg_reg[c] <= dv[c][33];
                end
            end
            nrf_pkg::DP_SQ:
            begin
                if (cmd.axis == nrf_pkg::AXIS_X)
                    d2_reg <= 64'(sq);
                else
                    d2_reg <= d2_reg + 64'(sq);
            end
            nrf_pkg::DP_DIVR_GO:  q1_reg <= quot[23:0];
            nrf_pkg::DP_TMUL:     t_reg  <= tprod[53:16];
            nrf_pkg::DP_MAG_SAVE:
            begin
                mag_reg <= (|quot[nrf_pkg::DIV_W-1:46]) ? nrf_pkg::MAG_CAP : quot[45:0];
            end
            nrf_pkg::DP_DMUL:     prod_reg <= dprod;
            nrf_pkg::DP_DACC:
            begin
                if (neg_reg[cmd.axis])
                    acc_reg[cmd.axis] <= acc_sel - term;
                else
                    acc_reg[cmd.axis] <= acc_sel + term;
            end
            nrf_pkg::DP_BIAS:     prod_reg <= 63'(bprod);
            nrf_pkg::DP_BACC:     acc_reg[2] <= acc_reg[2] + term;
            nrf_pkg::DP_SLO:
            begin
                prod_reg <= 63'(lo_prod);
                sat_reg  <= |m_abs[nrf_pkg::ACC_W-1:47];
            end
            nrf_pkg::DP_SHI:      prod2_reg <= hi_prod;
            nrf_pkg::DP_SSUM:     res_reg[cmd.axis] <= sat_out;
            nrf_pkg::DP_OUT:
            begin
                out_fx_reg     <= res_reg[0];
                out_fy_reg     <= res_reg[1];
                out_fz_reg     <= res_reg[2];
                out_active_reg <= active_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign status.nbr_valid = valid_reg[cmd.idx];
    assign status.outside   = |outside_c;
    assign status.in_band   = (d > nrf_pkg::NEAR_LIMIT) && (d < 32'(safe_dist_reg));
    assign status.div_busy  = div_busy;
    assign status.sqrt_busy = sqrt_busy;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_force_x = out_fx_reg;
    assign out_force_y = out_fy_reg;
    assign out_force_z = out_fz_reg;
    assign out_active  = out_active_reg;

endmodule

// ----- src/nrf_ctrl.sv -----
// ----------------------------------------------------------------------------
// nrf_ctrl
// Sequencer: walks the neighbor slots and steps the datapath per slot.
// ----------------------------------------------------------------------------
module nrf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_op,
    output logic                 in_ready,
    output nrf_pkg::dp_cmd_t     cmd,
    input  nrf_pkg::dp_status_t  status
);

    nrf_pkg::state_t           state_reg, state_next;
    logic [nrf_pkg::CNT_W-1:0] idx_reg, idx_next;
    nrf_pkg::axis_t            axis_reg, axis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nrf_pkg::ST_IDLE;
            idx_reg   <= '0;
            axis_reg  <= nrf_pkg::AXIS_X;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        axis_next  = axis_reg;
        in_ready   = 1'b0;
        cmd.op     = nrf_pkg::DP_NOP;
        cmd.idx    = idx_reg[nrf_pkg::IDX_W-1:0];
        cmd.axis   = axis_reg;
        case (state_reg)
            nrf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (nrf_pkg::item_op_t'(in_op) == nrf_pkg::ITEM_STORE)
                        cmd.op = nrf_pkg::DP_STORE;
                    else
                    begin
                        cmd.op     = nrf_pkg::DP_START;
                        idx_next   = '0;
                        state_next = nrf_pkg::ST_NEXT;
                    end
                end
            end
            nrf_pkg::ST_NEXT:
            begin
                if (idx_reg == nrf_pkg::CNT_W'(nrf_pkg::NEIGHBORS))
                begin
                    axis_next  = nrf_pkg::AXIS_X;
                    state_next = nrf_pkg::ST_SLO;
                end
                else if (status.nbr_valid)
                    state_next = nrf_pkg::ST_LOAD;
                else
                    idx_next = idx_reg + 1'b1;
            end
            nrf_pkg::ST_LOAD:
            begin
                cmd.op     = nrf_pkg::DP_LOAD;
                state_next = nrf_pkg::ST_GUARD;
            end
            nrf_pkg::ST_GUARD:
            begin
                if (status.outside)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = nrf_pkg::ST_NEXT;
                end
                else
                begin
                    axis_next  = nrf_pkg::AXIS_X;
                    state_next = nrf_pkg::ST_SQ;
                end
            end
            nrf_pkg::ST_SQ:
            begin
                cmd.op = nrf_pkg::DP_SQ;
                if (axis_reg == nrf_pkg::AXIS_Z)
                    state_next = nrf_pkg::ST_SQRT_GO;
                else
                    axis_next = nrf_pkg::axis_t'(axis_reg + 2'd1);
            end
            nrf_pkg::ST_SQRT_GO:
            begin
                cmd.op     = nrf_pkg::DP_SQRT_GO;
                state_next = nrf_pkg::ST_SQRT_WAIT;
            end
            nrf_pkg::ST_SQRT_WAIT:
            begin
                if (!status.sqrt_busy)
                    state_next = nrf_pkg::ST_BAND;
            end
            nrf_pkg::ST_BAND:
            begin
                if (status.in_band)
                begin
                    cmd.op     = nrf_pkg::DP_BAND_GO;
                    state_next = nrf_pkg::ST_DIVD_WAIT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = nrf_pkg::ST_NEXT;
                end
            end
            nrf_pkg::ST_DIVD_WAIT:
            begin
                if (!status.div_busy)
                    state_next = nrf_pkg::ST_DIVR;
            end
            nrf_pkg::ST_DIVR:
            begin
                cmd.op     = nrf_pkg::DP_DIVR_GO;
                state_next = nrf_pkg::ST_DIVR_WAIT;
            end
            nrf_pkg::ST_DIVR_WAIT:
            begin
                if (!status.div_busy)
                    state_next = nrf_pkg::ST_TMUL;
            end
            nrf_pkg::ST_TMUL:
            begin
                cmd.op     = nrf_pkg::DP_TMUL;
                state_next = nrf_pkg::ST_MAG_GO;
            end
            nrf_pkg::ST_MAG_GO:
            begin
                cmd.op     = nrf_pkg::DP_MAG_GO;
                state_next = nrf_pkg::ST_MAG_WAIT;
            end
            nrf_pkg::ST_MAG_WAIT:
            begin
                if (!status.div_busy)
                    state_next = nrf_pkg::ST_MAG_SAVE;
            end
            nrf_pkg::ST_MAG_SAVE:
            begin
                cmd.op     = nrf_pkg::DP_MAG_SAVE;
                axis_next  = nrf_pkg::AXIS_X;
                state_next = nrf_pkg::ST_DIR_GO;
            end
            nrf_pkg::ST_DIR_GO:
            begin
                cmd.op     = nrf_pkg::DP_DIR_GO;
                state_next = nrf_pkg::ST_DIR_WAIT;
            end
            nrf_pkg::ST_DIR_WAIT:
            begin
                if (!status.div_busy)
                    state_next = nrf_pkg::ST_DMUL;
            end
            nrf_pkg::ST_DMUL:
            begin
                cmd.op     = nrf_pkg::DP_DMUL;
                state_next = nrf_pkg::ST_DACC;
            end
            nrf_pkg::ST_DACC:
            begin
                cmd.op = nrf_pkg::DP_DACC;
                if (axis_reg == nrf_pkg::AXIS_Z)
                    state_next = nrf_pkg::ST_BIAS;
                else
                begin
                    axis_next  = nrf_pkg::axis_t'(axis_reg + 2'd1);
                    state_next = nrf_pkg::ST_DIR_GO;
                end
            end
            nrf_pkg::ST_BIAS:
            begin
                cmd.op     = nrf_pkg::DP_BIAS;
                state_next = nrf_pkg::ST_BACC;
            end
            nrf_pkg::ST_BACC:
            begin
                cmd.op     = nrf_pkg::DP_BACC;
                idx_next   = idx_reg + 1'b1;
                state_next = nrf_pkg::ST_NEXT;
            end
            nrf_pkg::ST_SLO:
            begin
                cmd.op     = nrf_pkg::DP_SLO;
                state_next = nrf_pkg::ST_SHI;
            end
            nrf_pkg::ST_SHI:
            begin
                cmd.op     = nrf_pkg::DP_SHI;
                state_next = nrf_pkg::ST_SSUM;
            end
            nrf_pkg::ST_SSUM:
            begin
                cmd.op = nrf_pkg::DP_SSUM;
                if (axis_reg == nrf_pkg::AXIS_Z)
                    state_next = nrf_pkg::ST_OUT;
                else
                begin
                    axis_next  = nrf_pkg::axis_t'(axis_reg + 2'd1);
                    state_next = nrf_pkg::ST_SLO;
                end
            end
            nrf_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = nrf_pkg::DP_OUT;
                    state_next = nrf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nrf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/neighbor_repulsion_force.sv -----
// ----------------------------------------------------------------------------
// neighbor_repulsion_force
// Potential-field repulsion from a table of neighbor positions, Q15.16.
// ----------------------------------------------------------------------------
// A store word (tuser 0) writes one neighbor slot and leaves the input ready.
// A compute word (tuser 1) returns one result word after a walk over all
// slots: an empty slot is skipped, a slot outside the radius box is dropped
// after the box test, one out of band after the distance root, and one
// inside the band runs through the 32-step root unit and makes six passes
// through the single bit-serial divider. The three sums are then scaled and
// saturated. A new word is taken as soon as the previous result sits in
// the output register.
// There is no clearing pass after reset.
module neighbor_repulsion_force (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [nrf_pkg::DATA_W-1:0]   s_tdata,   // slot, pos_x, pos_y, pos_z
    input  logic [nrf_pkg::USER_W-1:0]   s_tuser,   // op
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [nrf_pkg::DATA_W-1:0]   m_tdata,   // force_x, force_y, force_z, any_active
    input  logic                         cfg_we,
    input  logic [nrf_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [nrf_pkg::CFG_DW-1:0]   cfg_wdata
);

    nrf_pkg::dp_cmd_t    cmd;
    nrf_pkg::dp_status_t status;
    logic [31:0]         force_x;
    logic [31:0]         force_y;
    logic [31:0]         force_z;
    logic                any_active;

    nrf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_op    (s_tuser[0]),
        .in_ready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    nrf_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_slot     (s_tdata[2:0]),
        .in_pos_x    (signed'(s_tdata[34:3])),
        .in_pos_y    (signed'(s_tdata[66:35])),
        .in_pos_z    (signed'(s_tdata[98:67])),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_force_x (force_x),
        .out_force_y (force_y),
        .out_force_z (force_z),
        .out_active  (any_active)
    );

    assign m_tdata = {7'b0, any_active, force_z, force_y, force_x};

endmodule

// ----- src/nrf_checker.sv -----
// ----------------------------------------------------------------------------
// nrf_checker
// Port-level checks on handshake and word sequencing of the block.
// ----------------------------------------------------------------------------
`include "neighbor_repulsion_force_defines.svh"

module nrf_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [nrf_pkg::USER_W-1:0]  s_tuser,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [nrf_pkg::DATA_W-1:0]  m_tdata
);

    // stalled result word holds
    `NRF_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // a compute word takes the input ready away once it is accepted
    `NRF_ASSERT_NEXT(a_compute_busy, clk, rst_n, s_tvalid && s_tready && (s_tuser[0] == nrf_pkg::ITEM_COMPUTE), !s_tready, "input still ready after compute word")

    // a store word never stalls the input
    `NRF_ASSERT_NEXT(a_store_quick, clk, rst_n, s_tvalid && s_tready && (s_tuser[0] == nrf_pkg::ITEM_STORE), s_tready, "input stalled after store word")

    // a result only appears at the end of a compute
    `NRF_ASSERT_SAME(a_out_origin, clk, rst_n, $rose(m_tvalid), $past(!s_tready), "result word without compute")

endmodule

bind neighbor_repulsion_force nrf_checker u_nrf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stream testbench for the neighbor repulsion block: a table of directed
// words, then phases of random words clustered around neighbor positions,
// each phase under its own register setting. Results are checked against
// a bit-exact force model kept inside the bench or a directed row's own expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import nrf_pkg::*;

    localparam logic [CFG_AW-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_AW-1:0] REG_SPARE_B = 3'd7;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [31:0] fx;
        logic [31:0] fy;
        logic [31:0] fz;
        logic        act;
    } force_t;

    typedef enum logic { ROW_CFG, ROW_WORD } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [CFG_AW-1:0] addr;
        logic [31:0]       wdata;
        item_op_t          op;
        logic [2:0]        slot;
        logic [31:0]       x, y, z;
        bit                typed;
        force_t            want;
    } row_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata;
    logic [USER_W-1:0]   s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [DATA_W-1:0]   m_tdata;
    logic                cfg_we;
    logic [CFG_AW-1:0]   cfg_addr;
    logic [CFG_DW-1:0]   cfg_wdata;

    // model copy of the block state
    logic [31:0] nb_x [NEIGHBORS];
    logic [31:0] nb_y [NEIGHBORS];
    logic [31:0] nb_z [NEIGHBORS];
    bit          nb_ok [NEIGHBORS];
    logic [30:0] m_radius, m_gain;
    logic [31:0] m_scale, m_ofs_x, m_ofs_y, m_ofs_z;

    force_t pending_forces[$];
    row_t   rows[$];
    int     errors, n_store, n_compute, n_active, n_results;
    bit     hold_req, idle_on;

    neighbor_repulsion_force u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #500_000_000;
        $display("tb: errors");
        $finish;
    end

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned r, c;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if (c * c <= v)
                r = c;
        end
        return r;
    endfunction

    function automatic logic [31:0] scale_sat(longint s, longint unsigned sc);
        longint unsigned m, p;
        m = (s < 0) ? longint'(0) - s : s;
        if (m != 0 && m > 64'h7FFF_FFFF_FFFF_FFFF / sc)
            p = 64'd1 << 40;
        else
            p = (m * sc) >> 16;
        if (s < 0)
            return (p > 64'h8000_0000) ? 32'h8000_0000 : 32'(-longint'(p));
        return (p > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : p[31:0];
    endfunction

    function automatic longint axis_part(longint unsigned mag, longint unsigned a,
                                         longint dv, longint unsigned d);
        longint unsigned dir, c;
        dir = (a << 16) / d;
        c   = (mag * dir) >> 16;
        return (dv < 0) ? -longint'(c) : longint'(c);
    endfunction

    function automatic force_t repulsion(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        force_t          f;
        longint          ox, oy, oz, dx, dy, dz, sx, sy, sz;
        longint unsigned ax, ay, az, rad, d2, d, u, t, mag;
        logic [127:0]    q;
        ox = longint'($signed(px)) + longint'($signed(m_ofs_x));
        oy = longint'($signed(py)) + longint'($signed(m_ofs_y));
        oz = longint'($signed(pz)) + longint'($signed(m_ofs_z));
        rad = m_radius;
        sx = 0; sy = 0; sz = 0;
        f.act = 1'b0;
        for (int i = 0; i < NEIGHBORS; i++)
        begin
            if (!nb_ok[i])
                continue;
            dx = ox - longint'($signed(nb_x[i]));
            dy = oy - longint'($signed(nb_y[i]));
            dz = oz - longint'($signed(nb_z[i]));
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            az = (dz < 0) ? -dz : dz;
            if (ax >= rad || ay >= rad || az >= rad)
                continue;
            d2 = ax * ax + ay * ay + az * az;
            d  = root64(d2);
            if (d <= 655 || d >= rad)
                continue;
            f.act = 1'b1;
            u   = (64'd1 << 32) / d - (64'd1 << 32) / rad;
            t   = (64'(m_gain) * u) >> 16;
            q   = {32'd0, t, 32'd0} / {64'd0, d2};
            mag = (q > 128'h3FFF_FFFF_FFFF) ? 64'h3FFF_FFFF_FFFF : q[63:0];
            sx += axis_part(mag, ax, dx, d);
            sy += axis_part(mag, ay, dy, d);
            sz += axis_part(mag, az, dz, d);
            sz += longint'((mag * 3277) >> 16);
        end
        if ($signed(m_scale) <= 0)
        begin
            f.fx = '0; f.fy = '0; f.fz = '0;
        end
        else
        begin
            f.fx = scale_sat(sx, m_scale);
            f.fy = scale_sat(sy, m_scale);
            f.fz = scale_sat(sz, m_scale);
        end
        return f;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        force_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            if (pending_forces.size() == 0)
                report("unexpected word", m_tdata[31:0], 32'd0);
            else
            begin
                w = pending_forces.pop_front();
                if (m_tdata[31:0] !== w.fx)  report("force_x", m_tdata[31:0], w.fx);
                if (m_tdata[63:32] !== w.fy) report("force_y", m_tdata[63:32], w.fy);
                if (m_tdata[95:64] !== w.fz) report("force_z", m_tdata[95:64], w.fz);
                if (m_tdata[96] !== w.act)   report("any_active", m_tdata[96], w.act);
            end
        end
    end

    // receiver back-pressure, with one long hold-off on request
    initial
    begin
        int gap;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready = 1'b0;
                repeat (5000) @(negedge clk);
                hold_req = 1'b0;
            end
            if (idle_on && $urandom_range(0, 9) < 3)
            begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 3);
                m_tready = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
                m_tready = 1'b1;
        end
    end

    task automatic wait_drained();
        while (pending_forces.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] addr, logic [31:0] val);
        @(negedge clk);
        s_tvalid = 1'b0;
        wait_drained();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (addr)
            REG_SAFE_DIST: m_radius = val[30:0];
            REG_GAIN:      m_gain   = val[30:0];
            REG_SCALE:     m_scale  = val;
            REG_OFS_X:     m_ofs_x  = val;
            REG_OFS_Y:     m_ofs_y  = val;
            REG_OFS_Z:     m_ofs_z  = val;
            default: ;
        endcase
    endtask

    // send one word; typed expectation overrides the model when given
    task automatic send_word(item_op_t op, logic [2:0] slot, logic [31:0] x,
                             logic [31:0] y, logic [31:0] z, bit typed, force_t want);
        int gap;
        force_t f;
        if (idle_on && $urandom_range(0, 9) < 3)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                              : $urandom_range(1, 3);
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid = 1'b0;
            end
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {5'd0, z, y, x, slot};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (op == ITEM_STORE)
        begin
            nb_x[slot] = x; nb_y[slot] = y; nb_z[slot] = z;
            nb_ok[slot] = 1'b1;
            n_store++;
        end
        else
        begin
            f = repulsion(x, y, z);
            if (f.act) n_active++;
            pending_forces.insert(pending_forces.size(), typed ? want : f);
            n_compute++;
        end
    endtask

    function automatic void add_row(row_kind_t k, logic [CFG_AW-1:0] a, logic [31:0] v,
                                    item_op_t op, logic [2:0] s, logic [31:0] x,
                                    logic [31:0] y, logic [31:0] z, bit typed,
                                    logic act);
        row_t r;
        r.kind = k; r.addr = a; r.wdata = v; r.op = op; r.slot = s;
        r.x = x; r.y = y; r.z = z; r.typed = typed;
        r.want = '{fx: 32'd0, fy: 32'd0, fz: 32'd0, act: act};
        rows.insert(rows.size(), r);
    endfunction

    function automatic logic [31:0] near_val(int center, int span);
        return center + $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    initial
    begin
        force_t none;
        int rad, span, cx, cy, cz, nrand;
        errors = 0; n_store = 0; n_compute = 0; n_active = 0; n_results = 0;
        hold_req = 1'b0; idle_on = 1'b1;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
        cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
        none = '0;
        for (int i = 0; i < NEIGHBORS; i++)
        begin
            nb_x[i] = '0; nb_y[i] = '0; nb_z[i] = '0; nb_ok[i] = 1'b0;
        end
        m_radius = 31'd65536; m_gain = 31'd65536; m_scale = '0;
        m_ofs_x = '0; m_ofs_y = '0; m_ofs_z = '0;

        // empty table, then one neighbor at the origin under default registers
        add_row(ROW_WORD, 0, 0, ITEM_COMPUTE, 0, 0, 0, 0, 1, 1'b0);
        add_row(ROW_WORD, 0, 0, ITEM_STORE, 0, 0, 0, 0, 0, 1'b0);
        add_row(ROW_WORD, 0, 0, ITEM_COMPUTE, 0, 0, 0, 0, 1, 1'b0);
        // zero scale: forces zero, band still reported
        add_row(ROW_WORD, 0, 0, ITEM_COMPUTE, 0, 32768, 0, 0, 1, 1'b1);
        add_row(ROW_CFG, REG_SCALE, 65536, ITEM_STORE, 0, 0, 0, 0, 0, 1'b0);
        add_row(ROW_WORD, 0, 0, ITEM_COMPUTE, 0, 32768, 0, 0, 0, 1'b0);
        add_row(ROW_WORD, 0, 0, ITEM_COMPUTE, 0, -32768, 16384, -8192, 0, 1'b0);
        // near limit and radius edges, then extreme scale, positions, registers and offsets
        add_row(ROW_WORD, 0, 0, ITEM_COMPUTE, 0, 655, 0, 0, 1, 1'b0);
        add_row(ROW_WORD, 0, 0, ITEM_COMPUTE, 0, 656, 0, 0, 0, 1'b0);
        add_row(ROW_WORD, 0, 0, ITEM_COMPUTE, 0, 65536, 0, 0, 1, 1'b0);
        add_row(ROW_CFG, REG_SCALE, 32'h7FFF_FFFF, ITEM_STORE, 0, 0, 0, 0, 0, 1'b0);
        add_row(ROW_WORD, 0, 0, ITEM_COMPUTE, 0, 656, 0, 0, 0, 1'b0);
        add_row(ROW_WORD, 0, 0, ITEM_COMPUTE, 0, 0, -656, 0, 0, 1'b0);
        add_row(ROW_WORD, 0, 0, ITEM_STORE, 7, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 0, 1'b0);
        add_row(ROW_WORD, 0, 0, ITEM_STORE, 3, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 0, 1'b0);
        add_row(ROW_CFG, REG_SAFE_DIST, 32'h7FFF_FFFF, ITEM_STORE, 0, 0, 0, 0, 0, 1'b0);
        add_row(ROW_CFG, REG_GAIN, 32'h7FFF_FFFF, ITEM_STORE, 0, 0, 0, 0, 0, 1'b0);
        add_row(ROW_WORD, 0, 0, ITEM_COMPUTE, 0, 32'h7FFF_F000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 0, 1'b0);
        add_row(ROW_WORD, 0, 0, ITEM_COMPUTE, 0, 32'h8000_0000, 32'h8000_0100,
                32'h8000_0000, 0, 1'b0);
        add_row(ROW_CFG, REG_OFS_X, 32'h7FFF_FFFF, ITEM_STORE, 0, 0, 0, 0, 0, 1'b0);
        add_row(ROW_CFG, REG_OFS_Y, 32'h8000_0000, ITEM_STORE, 0, 0, 0, 0, 0, 1'b0);
        add_row(ROW_CFG, REG_OFS_Z, 32'h7FFF_FFFF, ITEM_STORE, 0, 0, 0, 0, 0, 1'b0);
        add_row(ROW_WORD, 0, 0, ITEM_COMPUTE, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h0, 0, 1'b0);
        // negative scale disables force; spare register indexes are ignored
        add_row(ROW_CFG, REG_SCALE, 32'h8000_0000, ITEM_STORE, 0, 0, 0, 0, 0, 1'b0);
        add_row(ROW_CFG, REG_SPARE_A, 32'hFFFF_FFFF, ITEM_STORE, 0, 0, 0, 0, 0, 1'b0);
        add_row(ROW_CFG, REG_SPARE_B, 32'h1234_5678, ITEM_STORE, 0, 0, 0, 0, 0, 1'b0);
        add_row(ROW_WORD, 0, 0, ITEM_COMPUTE, 0, 0, 0, 32'h7FFF_FFFF, 0, 1'b0);

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
                write_reg(rows[i].addr, rows[i].wdata);
            else
                send_word(rows[i].op, rows[i].slot, rows[i].x, rows[i].y, rows[i].z,
                          rows[i].typed, rows[i].want);
        end

        nrand = 0;
        for (int ph = 0; nrand < 1330; ph++)
        begin
            idle_on = (ph % 4 != 3);
            case ($urandom_range(0, 9))
                0:       rad = 0;
                1:       rad = 32'h7FFF_FFFF;
                2:       rad = $urandom() & 32'h7FFF_FFFF;
                default: rad = $urandom_range(16384, 262144);
            endcase
            write_reg(REG_SAFE_DIST, rad);
            write_reg(REG_GAIN, ($urandom_range(0, 7) == 0) ? $urandom()
                                                           : $urandom_range(0, 1 << 20));
            case ($urandom_range(0, 7))
                0:       write_reg(REG_SCALE, 0);
                1:       write_reg(REG_SCALE, $urandom() | 32'h8000_0000);
                2:       write_reg(REG_SCALE, $urandom());
                default: write_reg(REG_SCALE, $urandom_range(1, 1 << 18));
            endcase
            if ($urandom_range(0, 5) == 0)
            begin
                write_reg(REG_OFS_X, $urandom());
                write_reg(REG_OFS_Y, $urandom());
                write_reg(REG_OFS_Z, $urandom());
            end
            else
            begin
                write_reg(REG_OFS_X, near_val(0, 1 << 22));
                write_reg(REG_OFS_Y, near_val(0, 1 << 22));
                write_reg(REG_OFS_Z, near_val(0, 1 << 22));
            end
            // occasional noise write to a spare index
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom());
            if (ph == 2)
                hold_req = 1'b1;

            span = (rad > 0 && rad < (1 << 20)) ? 2 * rad : (1 << 20);
            cx = near_val(0, 1 << 29);
            cy = near_val(0, 1 << 29);
            cz = near_val(0, 1 << 29);
            for (int k = 0; k < 120 && nrand < 1330; k++)
            begin
                if (ph == 5 && k == 60)
                begin
                    @(negedge clk);
                    s_tvalid = 1'b0;
                    wait_drained();
                end
                if ($urandom_range(0, 9) == 0)
                    send_word(item_op_t'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                              $urandom(), $urandom(), $urandom(), 0, none);
                else if ($urandom_range(0, 9) < 6)
                    send_word(ITEM_STORE, 3'($urandom_range(0, 7)), near_val(cx, span),
                              near_val(cy, span), near_val(cz, span), 0, none);
                else
                    send_word(ITEM_COMPUTE, 3'($urandom_range(0, 7)),
                              near_val(cx, span) - m_ofs_x, near_val(cy, span) - m_ofs_y,
                              near_val(cz, span) - m_ofs_z, 0, none);
                nrand++;
            end
        end

        @(negedge clk);
        s_tvalid = 1'b0;
        wait_drained();
        repeat (100) @(posedge clk);
        if (pending_forces.size() != 0)
            report("words never returned", pending_forces.size(), 0);
        $display("tb: %0d store and %0d compute words, %0d results, %0d in band",
                 n_store, n_compute, n_results, n_active);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/nrf_pkg.sv
src/nrf_div.sv
src/nrf_sqrt.sv
src/nrf_datapath.sv
src/nrf_ctrl.sv
src/neighbor_repulsion_force.sv
src/nrf_checker.sv
sim/tb.sv
